>>> rtl/vehicle_link_mode_supervisor_defines.svh
// ----------------------------------------------------------------------------
// Vehicle link mode supervisor assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VEHICLE_LINK_MODE_SUPERVISOR_DEFINES_SVH
`define VEHICLE_LINK_MODE_SUPERVISOR_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is high.
`define VLMS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vlms assertion failed");
// Clocked assertion that also holds during reset.
`define VLMS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("vlms assertion failed");
`else
`define VLMS_ASSERT(label, clk, rst, prop)
`define VLMS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/vlms_pkg.sv
// ----------------------------------------------------------------------------
// Vehicle link mode supervisor package
// Mode, transaction kind and register codes plus the mode transition function.
// ----------------------------------------------------------------------------
package vlms_pkg;

   localparam int AGE_BITS     = 16;
   localparam int TIMEOUT_BITS = 16;
   localparam int BATTERY_BITS = 7;
   localparam int MODE_BITS    = 3;
   localparam int KIND_BITS    = 2;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 16;
   localparam int CMP_BITS     = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;

   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

   localparam logic [BATTERY_BITS-1:0] BATTERY_MIN_RST      = BATTERY_BITS'(20);
   localparam logic [TIMEOUT_BITS-1:0] LINK_TIMEOUT_RST     = TIMEOUT_BITS'(1500);
   localparam logic [TIMEOUT_BITS-1:0] ODOM_STALE_LIMIT_RST = TIMEOUT_BITS'(1500);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_UNKNOWN     = 3'd0,
      MODE_READY       = 3'd1,
      MODE_FLIGHT      = 3'd2,
      MODE_READY_ODOM  = 3'd3,
      MODE_FLIGHT_ODOM = 3'd4,
      MODE_LOW_BATTERY = 3'd5
   } mode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_STATUS = 2'd0,
      KIND_ODOM   = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_ACTION = 2'd3
   } kind_type;

   typedef enum logic {
      ACTION_TAKEOFF = 1'b0,
      ACTION_LAND    = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      EV_CONNECTED    = 3'd0,
      EV_DISCONNECTED = 3'd1,
      EV_ODOM_STARTED = 3'd2,
      EV_ODOM_STOPPED = 3'd3,
      EV_LOW_BATTERY  = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BATTERY_MIN      = 2'd0,
      CSR_LINK_TIMEOUT     = 2'd1,
      CSR_ODOM_STALE_LIMIT = 2'd2
   } csr_index_type;

   // Next mode after one supervisory event; disallowed events leave the mode.
   function automatic mode_type apply_event(mode_type m, event_type ev);
      mode_type n;
      n = m;
      unique case (m)
         MODE_UNKNOWN: begin
            if (ev == EV_CONNECTED) n = MODE_READY;
         end
         MODE_READY, MODE_FLIGHT: begin
            if (ev == EV_DISCONNECTED) n = MODE_UNKNOWN;
            else if (ev == EV_ODOM_STARTED)
               n = (m == MODE_READY) ? MODE_READY_ODOM : MODE_FLIGHT_ODOM;
            else if (ev == EV_LOW_BATTERY) n = MODE_LOW_BATTERY;
         end
         MODE_READY_ODOM, MODE_FLIGHT_ODOM: begin
            if (ev == EV_DISCONNECTED) n = MODE_UNKNOWN;
            else if (ev == EV_ODOM_STOPPED)
               n = (m == MODE_READY_ODOM) ? MODE_READY : MODE_FLIGHT;
            else if (ev == EV_LOW_BATTERY) n = MODE_LOW_BATTERY;
         end
         MODE_LOW_BATTERY: begin
            if (ev == EV_DISCONNECTED) n = MODE_UNKNOWN;
         end
         default: n = m;
      endcase
      return n;
   endfunction

   // Next mode after a completed takeoff or land.
   function automatic mode_type apply_action(mode_type m, action_type act);
      mode_type n;
      n = m;
      if (act == ACTION_TAKEOFF) begin
         if (m == MODE_READY) n = MODE_FLIGHT;
         else if (m == MODE_READY_ODOM) n = MODE_FLIGHT_ODOM;
      end else begin
         if (m == MODE_FLIGHT) n = MODE_READY;
         else if (m == MODE_FLIGHT_ODOM) n = MODE_READY_ODOM;
      end
      return n;
   endfunction

endpackage

>>> rtl/vehicle_link_mode_supervisor.sv
// ----------------------------------------------------------------------------
// Vehicle link mode supervisor
// Six-mode supervisory machine driven by status, odometry, tick and action
// transactions, with saturating link and odometry watchdogs.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   req     | in        | req_valid / req_ready  | kind, battery, action
//   rsp     | out       | rsp_valid / rsp_ready  | mode, mode_changed,
//           |           |                        | link_live, odom_live
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// Each request transaction updates the mode, age and seen registers at the
// accepting edge and loads the response into the output register at that same
// edge. One transaction per cycle is sustained while rsp_ready stays high; the
// single response register sets that figure, and req_ready drops only while
// that register holds an unconsumed response. Synchronous reset restores the
// register defaults, mode unknown and both watchdogs idle. csr_ready is
// always high.
//
module vehicle_link_mode_supervisor
   import vlms_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [KIND_BITS-1:0]    req_kind,
   input  logic [BATTERY_BITS-1:0] req_battery,
   input  logic                    req_action,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [MODE_BITS-1:0]    rsp_mode,
   output logic                    rsp_mode_changed,
   output logic                    rsp_link_live,
   output logic                    rsp_odom_live,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DAT_BITS-1:0] csr_data
);

`include "vehicle_link_mode_supervisor_defines.svh"

   // Configuration registers
   logic [BATTERY_BITS-1:0] battery_min_ff,      battery_min_in;
   logic [TIMEOUT_BITS-1:0] link_timeout_ff,     link_timeout_in;
   logic [TIMEOUT_BITS-1:0] odom_stale_limit_ff, odom_stale_limit_in;

   // Supervisor state
   mode_type              current_mode_ff, current_mode_in;
   logic [AGE_BITS-1:0]   link_age_ff, link_age_in;
   logic [AGE_BITS-1:0]   odom_age_ff, odom_age_in;
   logic                  link_seen_ff, link_seen_in;
   logic                  odom_seen_ff, odom_seen_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MODE_BITS-1:0]  rsp_mode_ff, rsp_mode_in;
   logic                  rsp_changed_ff, rsp_changed_in;
   logic                  rsp_link_ff, rsp_link_in;
   logic                  rsp_odom_ff, rsp_odom_in;

   logic                  req_fire;
   logic                  csr_fire;

   // Step values
   mode_type              mode_step;
   logic [AGE_BITS-1:0]   link_age_step, odom_age_step;
   logic                  link_seen_step, odom_seen_step;
   mode_type              mode_conn;
   logic [AGE_BITS-1:0]   link_age_inc, odom_age_inc;
   logic                  link_expired, odom_expired;
   mode_type              mode_tick;

   // Accept a new request whenever the response slot is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // ---------------------------------------------------------------------
   // Configuration writes; an unknown index is dropped.
   // ---------------------------------------------------------------------
   always_comb begin
      battery_min_in      = battery_min_ff;
      link_timeout_in     = link_timeout_ff;
      odom_stale_limit_in = odom_stale_limit_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_BATTERY_MIN:      battery_min_in      = csr_data[BATTERY_BITS-1:0];
            CSR_LINK_TIMEOUT:     link_timeout_in     = csr_data[TIMEOUT_BITS-1:0];
            CSR_ODOM_STALE_LIMIT: odom_stale_limit_in = csr_data[TIMEOUT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog aging for a tick: advance only seen ages, saturating at max.
   // The odometry check is skipped when the link expires on the same tick.
   // ---------------------------------------------------------------------
   assign link_age_inc = (link_seen_ff && link_age_ff != AGE_MAX) ?
                         AGE_BITS'(link_age_ff + 1'b1) : link_age_ff;
   assign odom_age_inc = (odom_seen_ff && odom_age_ff != AGE_MAX) ?
                         AGE_BITS'(odom_age_ff + 1'b1) : odom_age_ff;
   assign link_expired = link_seen_ff &&
                         (CMP_BITS'(link_age_inc) > CMP_BITS'(link_timeout_ff));
   assign odom_expired = odom_seen_ff && !link_expired &&
                         (CMP_BITS'(odom_age_inc) > CMP_BITS'(odom_stale_limit_ff));

   always_comb begin
      mode_tick = current_mode_ff;
      if (link_expired) mode_tick = apply_event(current_mode_ff, EV_DISCONNECTED);
      else if (odom_expired) mode_tick = apply_event(current_mode_ff, EV_ODOM_STOPPED);
   end

   // Connected event for a status report arriving on a dead link.
   assign mode_conn = link_seen_ff ? current_mode_ff
                                   : apply_event(current_mode_ff, EV_CONNECTED);

   // ---------------------------------------------------------------------
   // One request transaction: next state from the current state.
   // ---------------------------------------------------------------------
   always_comb begin
      mode_step      = current_mode_ff;
      link_age_step  = link_age_ff;
      odom_age_step  = odom_age_ff;
      link_seen_step = link_seen_ff;
      odom_seen_step = odom_seen_ff;
      unique case (kind_type'(req_kind))
         KIND_STATUS: begin
            mode_step = mode_conn;
            if (req_battery < battery_min_ff && mode_conn != MODE_LOW_BATTERY)
               mode_step = apply_event(mode_conn, EV_LOW_BATTERY);
            link_seen_step = 1'b1;
            link_age_step  = '0;
         end
         KIND_ODOM: begin
            // Drop odometry while the link is down.
            if (link_seen_ff) begin
               if (!odom_seen_ff)
                  mode_step = apply_event(current_mode_ff, EV_ODOM_STARTED);
               odom_seen_step = 1'b1;
               odom_age_step  = '0;
            end
         end
         KIND_TICK: begin
            mode_step     = mode_tick;
            link_age_step = link_age_inc;
            odom_age_step = odom_age_inc;
            if (link_expired) begin
               link_seen_step = 1'b0;
               odom_seen_step = 1'b0;
               link_age_step  = '0;
               odom_age_step  = '0;
            end else if (odom_expired) begin
               odom_seen_step = 1'b0;
               odom_age_step  = '0;
            end
         end
         KIND_ACTION: begin
            mode_step = apply_action(current_mode_ff, action_type'(req_action));
         end
         default: ;
      endcase
   end

   // Commit state and load the response on an accepted request.
   always_comb begin
      current_mode_in = current_mode_ff;
      link_age_in     = link_age_ff;
      odom_age_in     = odom_age_ff;
      link_seen_in    = link_seen_ff;
      odom_seen_in    = odom_seen_ff;
      rsp_mode_in     = rsp_mode_ff;
      rsp_changed_in  = rsp_changed_ff;
      rsp_link_in     = rsp_link_ff;
      rsp_odom_in     = rsp_odom_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         current_mode_in = mode_step;
         link_age_in     = link_age_step;
         odom_age_in     = odom_age_step;
         link_seen_in    = link_seen_step;
         odom_seen_in    = odom_seen_step;
         rsp_mode_in     = mode_step;
         rsp_changed_in  = (mode_step != current_mode_ff);
         rsp_link_in     = link_seen_step;
         rsp_odom_in     = odom_seen_step;
         rsp_valid_in    = 1'b1;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         battery_min_ff      <= BATTERY_MIN_RST;
         link_timeout_ff     <= LINK_TIMEOUT_RST;
         odom_stale_limit_ff <= ODOM_STALE_LIMIT_RST;
         current_mode_ff     <= MODE_UNKNOWN;
         link_age_ff         <= '0;
         odom_age_ff         <= '0;
         link_seen_ff        <= 1'b0;
         odom_seen_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         battery_min_ff      <= battery_min_in;
         link_timeout_ff     <= link_timeout_in;
         odom_stale_limit_ff <= odom_stale_limit_in;
         current_mode_ff     <= current_mode_in;
         link_age_ff         <= link_age_in;
         odom_age_ff         <= odom_age_in;
         link_seen_ff        <= link_seen_in;
         odom_seen_ff        <= odom_seen_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // Response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_mode_ff    <= rsp_mode_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_link_ff    <= rsp_link_in;
      rsp_odom_ff    <= rsp_odom_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = rsp_mode_ff;
   assign rsp_mode_changed = rsp_changed_ff;
   assign rsp_link_live    = rsp_link_ff;
   assign rsp_odom_live    = rsp_odom_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A live link always has left the unknown mode.
   `VLMS_ASSERT(a_link_not_unknown, clock, reset, link_seen_ff |-> current_mode_ff != MODE_UNKNOWN)
   // Odometry modes only exist while odometry is being tracked.
   `VLMS_ASSERT(a_odom_mode_seen, clock, reset, (current_mode_ff == MODE_READY_ODOM || current_mode_ff == MODE_FLIGHT_ODOM) |-> odom_seen_ff)
   // A held response blocks the request side.
   `VLMS_ASSERT(a_stall_blocks, clock, reset, (rsp_valid_ff && !rsp_ready) |-> !req_ready)
   // The change flag matches the mode before and after the transaction.
   `VLMS_ASSERT(a_changed_flag, clock, reset, req_fire |=> rsp_changed_ff == (rsp_mode_ff != $past(current_mode_ff)))

endmodule
